### hdl/wcat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcat_pkg
// Shared types and constants of the wall clock with alarm table.
// ----------------------------------------------------------------------------
package wcat_pkg;

    localparam int SLOT_COUNT = 16;
    // The slot field is four bits wide, so at most sixteen slots are reachable.
    localparam int SLOT_NUM = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;
    localparam int SLOT_IW  = (SLOT_NUM > 1) ? $clog2(SLOT_NUM) : 1;
    localparam int SLOT_CW  = $clog2(SLOT_NUM + 1);

    localparam logic [30:0] NSEC_PER_SEC = 31'd1000000000;
    localparam logic [30:0] NSEC_TWO_SEC = 31'd2000000000;
    localparam logic [29:0] NSEC_MAX     = 30'd999999999;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ARM  = 2'd1;
    localparam logic [1:0] OP_SCAN = 2'd2;

    localparam logic [1:0] CFG_COUNT_MODE     = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_NSEC = 2'd1;
    localparam logic [1:0] CFG_NSEC_PER_TICK  = 2'd2;

    typedef struct packed {
        logic        tick;
        logic [31:0] delay_sec;
        logic [29:0] delay_nsec;
    } t_tk_cmd;

    typedef struct packed {
        logic [63:0] sec;
        logic [29:0] nsec;
        logic [63:0] dl_sec;
        logic [29:0] dl_nsec;
    } t_tk_stat;

endpackage

### hdl/wcat_timekeep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcat_timekeep
// Clock registers, tick divider and configuration; computes alarm deadlines.
// ----------------------------------------------------------------------------
module wcat_timekeep import wcat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_tk_cmd     i_cmd,
    output t_tk_stat    o_stat
);

    logic        r_mode;
    logic [31:0] r_tpn;
    logic [29:0] r_npt;
    logic [63:0] r_sec;
    logic [29:0] r_nsec;
    logic [31:0] r_phase;

    logic [63:0] n_sec;
    logic [29:0] n_nsec;
    logic [31:0] n_phase;

    logic [31:0] div;
    logic [32:0] phase_inc;
    logic [29:0] nsec_inc;
    logic [30:0] inc_sum;
    logic [29:0] arm_ns;
    logic [30:0] arm_sum;
    logic        arm_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_tpn  <= 32'd1;
            r_npt  <= 30'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COUNT_MODE:     r_mode <= i_cfg_data[0];
                CFG_TICKS_PER_NSEC: r_tpn  <= i_cfg_data;
                CFG_NSEC_PER_TICK:  r_npt  <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        div       = (r_tpn == 32'd0) ? 32'd1 : r_tpn;
        phase_inc = {1'b0, r_phase} + 33'd1;
        nsec_inc  = r_nsec + 30'd1;
        inc_sum   = {1'b0, r_nsec} + {1'b0, r_npt};
        n_sec     = r_sec;
        n_nsec    = r_nsec;
        n_phase   = r_phase;
        if (i_cmd.tick) begin
            if (!r_mode) begin
                if (phase_inc >= {1'b0, div}) begin
                    n_phase = 32'd0;
                    if ({1'b0, nsec_inc} == NSEC_PER_SEC) begin
                        n_nsec = 30'd0;
                        n_sec  = r_sec + 64'd1;
                    end else begin
                        n_nsec = nsec_inc;
                    end
                end else begin
                    n_phase = phase_inc[31:0];
                end
            end else begin
                // sum stays below three seconds, so two compares cover the carry
                priority if (inc_sum >= NSEC_TWO_SEC) begin
                    n_nsec = 30'(inc_sum - NSEC_TWO_SEC);
                    n_sec  = r_sec + 64'd2;
                end else if (inc_sum >= NSEC_PER_SEC) begin
                    n_nsec = 30'(inc_sum - NSEC_PER_SEC);
                    n_sec  = r_sec + 64'd1;
                end else begin
                    n_nsec = inc_sum[29:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec   <= 64'd0;
            r_nsec  <= 30'd0;
            r_phase <= 32'd0;
        end else begin
            r_sec   <= n_sec;
            r_nsec  <= n_nsec;
            r_phase <= n_phase;
        end
    end

    // deadline = now + delay, nanoseconds saturated and normalized
    always_comb begin
        arm_ns    = (i_cmd.delay_nsec > NSEC_MAX) ? NSEC_MAX : i_cmd.delay_nsec;
        arm_sum   = {1'b0, r_nsec} + {1'b0, arm_ns};
        arm_carry = (arm_sum >= NSEC_PER_SEC);
        o_stat.sec     = r_sec;
        o_stat.nsec    = r_nsec;
        o_stat.dl_nsec = arm_carry ? 30'(arm_sum - NSEC_PER_SEC) : arm_sum[29:0];
        o_stat.dl_sec  = r_sec + {32'd0, i_cmd.delay_sec} + {63'd0, arm_carry};
    end

endmodule

### hdl/wall_clock_with_alarm_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_clock_with_alarm_table_unit
// Seconds/nanoseconds clock with a table of alarm deadlines in a memory.
// ----------------------------------------------------------------------------
// Tick, arm and unused ops: each request is accepted, then executed once the
// output is free, and gives one result. Scan: the deadline memory is read one
// slot per cycle, unless a held hit waits for the output, through its single
// registered read port.
// Reset clears the clock, the divider phase, the armed bits and the config;
// the deadline memory is not cleared and needs no clearing pass.
module wall_clock_with_alarm_table_unit import wcat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_delay_sec,
    input  logic [29:0] i_delay_nsec,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fired,
    output logic [3:0]  o_woken_slot,
    output logic [63:0] o_time_sec,
    output logic [29:0] o_time_nsec,
    output logic        o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_op;
    logic [3:0]         r_slot;
    logic [31:0]        r_dsec;
    logic [29:0]        r_dnsec;

    logic [SLOT_NUM-1:0] r_armed, n_armed;
    logic [93:0]         r_mem [SLOT_NUM];
    logic [63:0]         r_rd_sec;
    logic [29:0]         r_rd_nsec;

    logic [SLOT_CW-1:0]  r_ra, n_ra;
    logic                r_cv, n_cv;
    logic [SLOT_IW-1:0]  r_ci, n_ci;
    logic                r_pend, n_pend;
    logic [SLOT_IW-1:0]  r_pend_slot, n_pend_slot;

    logic                r_out_valid;
    logic                r_fired, n_fired;
    logic [3:0]          r_wslot, n_wslot;
    logic                r_last, n_last;
    logic                out_load;

    logic                mem_we, mem_re;
    logic                out_free, due, hit, stall, slot_ok;
    logic                in_acc;

    t_tk_cmd             tk_cmd;
    t_tk_stat            tk_stat;

    wcat_timekeep u_timekeep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (tk_cmd),
        .o_stat     (tk_stat)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign slot_ok  = (5'(r_slot) < 5'(SLOT_NUM));
    assign due      = {tk_stat.sec, tk_stat.nsec} >= {r_rd_sec, r_rd_nsec};
    assign hit      = r_cv && r_armed[r_ci] && due;
    // a second hit cannot move while the held one still waits for the output
    assign stall    = hit && r_pend && !out_free;

    assign tk_cmd.tick       = (r_state == ST_EXEC) && (r_op == OP_TICK) && out_free;
    assign tk_cmd.delay_sec  = r_dsec;
    assign tk_cmd.delay_nsec = r_dnsec;

    always_comb begin
        n_state     = r_state;
        n_armed     = r_armed;
        n_ra        = r_ra;
        n_cv        = r_cv;
        n_ci        = r_ci;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_fired     = r_fired;
        n_wslot     = r_wslot;
        n_last      = r_last;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_op == OP_SCAN) begin
                    n_ra    = '0;
                    n_cv    = 1'b0;
                    n_pend  = 1'b0;
                    n_state = ST_SCAN;
                end else if (out_free) begin
                    if (r_op == OP_ARM && slot_ok) begin
                        mem_we                   = 1'b1;
                        n_armed[r_slot[SLOT_IW-1:0]] = 1'b1;
                    end
                    out_load = 1'b1;
                    n_fired  = 1'b0;
                    n_wslot  = 4'd0;
                    n_last   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (hit) begin
                        // release the previous hit, hold this one until the next
                        if (r_pend) begin
                            out_load = 1'b1;
                            n_fired  = 1'b1;
                            n_wslot  = 4'(r_pend_slot);
                            n_last   = 1'b0;
                        end
                        n_pend        = 1'b1;
                        n_pend_slot   = r_ci;
                        n_armed[r_ci] = 1'b0;
                    end
                    if (r_ra < SLOT_CW'(SLOT_NUM)) begin
                        mem_re = 1'b1;
                        n_ci   = r_ra[SLOT_IW-1:0];
                        n_cv   = 1'b1;
                        n_ra   = r_ra + SLOT_CW'(1);
                    end else begin
                        n_cv = 1'b0;
                        if (!r_cv) begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_fired  = r_pend;
                    n_wslot  = r_pend ? 4'(r_pend_slot) : 4'd0;
                    n_last   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_armed     <= '0;
            r_ra        <= '0;
            r_cv        <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_armed <= n_armed;
            r_ra    <= n_ra;
            r_cv    <= n_cv;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ci        <= n_ci;
        r_pend_slot <= n_pend_slot;
        r_fired     <= n_fired;
        r_wslot     <= n_wslot;
        r_last      <= n_last;
        if (in_acc) begin
            r_op    <= i_op;
            r_slot  <= i_slot;
            r_dsec  <= i_delay_sec;
            r_dnsec <= i_delay_nsec;
        end
    end

    // deadline memory: one write port, one registered read port; an arm
    // completes before the next request is taken, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot[SLOT_IW-1:0]] <= {tk_stat.dl_sec, tk_stat.dl_nsec};
        end
        if (mem_re) begin
            {r_rd_sec, r_rd_nsec} <= r_mem[r_ra[SLOT_IW-1:0]];
        end
    end

    // the clock only moves on the edge that loads a new result
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_fired      = r_fired;
    assign o_woken_slot = r_wslot;
    assign o_time_sec   = tk_stat.sec;
    assign o_time_nsec  = tk_stat.nsec;
    assign o_last       = r_last;

endmodule

### hdl/wcat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcat_checker
// Port-level checks of the wall clock with alarm table, bound to the top.
// ----------------------------------------------------------------------------
module wcat_checker import wcat_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_fired,
    input logic [3:0]  o_woken_slot,
    input logic [63:0] o_time_sec,
    input logic [29:0] o_time_nsec,
    input logic        o_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_fired) &&
            $stable(o_woken_slot) && $stable(o_time_sec) && $stable(o_last))
        else $error("stalled result changed");

    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_fired |-> o_woken_slot == 4'd0)
        else $error("empty result carries a slot");

    a_nsec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {1'b0, o_time_nsec} < NSEC_PER_SEC)
        else $error("nanoseconds out of range");

    // a scan in progress blocks new requests and keeps the time
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("request taken in the middle of a scan");

    a_scan_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |=> $stable(o_time_sec) && $stable(o_time_nsec))
        else $error("time moved during a scan");

endmodule

bind wall_clock_with_alarm_table_unit wcat_checker u_wcat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_fired      (o_fired),
    .o_woken_slot (o_woken_slot),
    .o_time_sec   (o_time_sec),
    .o_time_nsec  (o_time_nsec),
    .o_last       (o_last)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the wall clock with alarm table. A directed table of
// requests, then random traffic over several clock settings, is driven
// through the valid/ready request channel. Every report is compared field by
// field with a typed row or with a clock and alarm predictor kept alongside.
// ----------------------------------------------------------------------------
module tb;
    import wcat_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIR_ROWS = 21;

    typedef struct packed {
        logic        fired;
        logic [3:0]  slot;
        logic [63:0] sec;
        logic [29:0] nsec;
        logic        last;
    } clock_report_t;

    // One request; typed rows carry their single report, seconds zero.
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [31:0] dsec;
        logic [29:0] dnsec;
        logic        typed;
        logic        fired;
        logic [3:0]  wslot;
        logic [29:0] nsec;
    } request_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [3:0]  i_slot;
    logic [31:0] i_delay_sec;
    logic [29:0] i_delay_nsec;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_fired;
    logic [3:0]  o_woken_slot;
    logic [63:0] o_time_sec;
    logic [29:0] o_time_nsec;
    logic        o_last;

    // Predicted clock, alarm table and settings
    logic [63:0] clk_sec;
    logic [29:0] clk_nsec;
    logic [31:0] div_phase;
    logic        slot_armed [SLOT_NUM];
    logic [63:0] due_sec [SLOT_NUM];
    logic [29:0] due_nsec [SLOT_NUM];
    logic        cfg_mode;
    logic [31:0] cfg_ticks;
    logic [29:0] cfg_step;

    clock_report_t awaited_reports [$];
    int  mismatch_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  want_hold_off = 1'b0;
    bit  hold_off_done = 1'b0;

    request_row_t directed_rows [DIR_ROWS] = '{
        '{OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 1'b1, 1'b0, 4'd0, 30'd0},
        '{OP_SCAN, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd0},
        '{OP_TICK, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd1},
        '{OP_ARM, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd1},
        // largest delay: nanoseconds saturate, carry lands in seconds
        '{OP_ARM, 4'd15, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 1'b1, 1'b0, 4'd0, 30'd1},
        '{OP_ARM, 4'd7, 32'd0, 30'd999999999, 1'b1, 1'b0, 4'd0, 30'd1},
        '{OP_SCAN, 4'd0, 32'd0, 30'd0, 1'b1, 1'b1, 4'd0, 30'd1},
        '{OP_ARM, 4'd3, 32'd0, 30'd2, 1'b1, 1'b0, 4'd0, 30'd1},
        '{OP_TICK, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd2},
        '{OP_SCAN, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd2},
        '{OP_TICK, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd3},
        '{OP_ARM, 4'd4, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd3},
        // one above the nanosecond range
        '{OP_ARM, 4'd10, 32'd0, 30'd1000000000, 1'b1, 1'b0, 4'd0, 30'd3},
        // slot 7 has the larger second but the smaller nanosecond: stays armed
        '{OP_SCAN, 4'd0, 32'd0, 30'd0, 1'b0, 1'b0, 4'd0, 30'd0},
        '{OP_ARM, 4'd8, 32'd0, 30'd1, 1'b1, 1'b0, 4'd0, 30'd3},
        '{OP_ARM, 4'd8, 32'd0, 30'd5, 1'b1, 1'b0, 4'd0, 30'd3},
        '{OP_TICK, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd4},
        '{OP_SCAN, 4'd0, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd4},
        '{OP_ARM, 4'd1, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd4},
        '{OP_ARM, 4'd2, 32'd0, 30'd0, 1'b1, 1'b0, 4'd0, 30'd4},
        '{OP_SCAN, 4'd0, 32'd0, 30'd0, 1'b0, 1'b0, 4'd0, 30'd0}
    };

    wall_clock_with_alarm_table_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_slot       (i_slot),
        .i_delay_sec  (i_delay_sec),
        .i_delay_nsec (i_delay_nsec),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_fired      (o_fired),
        .o_woken_slot (o_woken_slot),
        .o_time_sec   (o_time_sec),
        .o_time_nsec  (o_time_nsec),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic void compute_clock_reports(input logic [1:0] op,
                                                  input logic [3:0] slot,
                                                  input logic [31:0] dsec,
                                                  input logic [29:0] dnsec,
                                                  output clock_report_t reps [$]);
        logic [32:0] divisor;
        logic [32:0] next_phase;
        logic [29:0] capped;
        longint unsigned sum;
        reps = {};
        case (op)
            OP_TICK: begin
                if (cfg_mode == 1'b0) begin
                    divisor = (cfg_ticks == 32'd0) ? 33'd1 : {1'b0, cfg_ticks};
                    next_phase = {1'b0, div_phase} + 33'd1;
                    if (next_phase >= divisor) begin
                        div_phase = '0;
                        sum = clk_nsec + 1;
                    end else begin
                        div_phase = next_phase[31:0];
                        sum = clk_nsec;
                    end
                end else begin
                    sum = clk_nsec + cfg_step;
                end
                clk_sec = clk_sec + sum / NSEC_PER_SEC;
                clk_nsec = 30'(sum % NSEC_PER_SEC);
            end
            OP_ARM: begin
                if (slot < SLOT_NUM) begin
                    capped = (dnsec > NSEC_MAX) ? NSEC_MAX : dnsec;
                    sum = clk_nsec + capped;
                    due_sec[slot] = clk_sec + 64'(dsec) + sum / NSEC_PER_SEC;
                    due_nsec[slot] = 30'(sum % NSEC_PER_SEC);
                    slot_armed[slot] = 1'b1;
                end
            end
            OP_SCAN: begin
                for (int i = 0; i < SLOT_NUM; i++) begin
                    if (slot_armed[i] && (clk_sec > due_sec[i] ||
                        (clk_sec == due_sec[i] && clk_nsec >= due_nsec[i]))) begin
                        slot_armed[i] = 1'b0;
                        reps.push_back('{1'b1, 4'(i), clk_sec, clk_nsec, 1'b0});
                    end
                end
            end
            default: ;
        endcase
        if (reps.size() == 0)
            reps.push_back('{1'b0, 4'd0, clk_sec, clk_nsec, 1'b1});
        else
            reps[reps.size() - 1].last = 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            note_mismatch(what, want, got);
    endtask

    // Offer one request, then predict its reports once it is taken.
    task automatic push_request(input request_row_t rq);
        clock_report_t reps [$];
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= rq.op;
        i_slot       <= rq.slot;
        i_delay_sec  <= rq.dsec;
        i_delay_nsec <= rq.dnsec;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        compute_clock_reports(rq.op, rq.slot, rq.dsec, rq.dnsec, reps);
        if (rq.typed)
            awaited_reports.push_back('{rq.fired, rq.wslot, 64'd0, rq.nsec, 1'b1});
        else
            foreach (reps[k])
                awaited_reports.push_back(reps[k]);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        request_row_t rq;
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            rq = '0;
            rq.slot  = 4'($urandom);
            rq.dsec  = $urandom;
            rq.dnsec = 30'($urandom);
            if (pick < 40) begin
                rq.op = OP_TICK;
            end else if (pick < 70) begin
                rq.op = OP_ARM;
                pick = $urandom_range(9);
                // keep the full-range delay one time in ten
                if (pick == 1) begin
                    rq.dsec  = 32'd0;
                    rq.dnsec = 30'd0;
                end else if (pick != 0 && cfg_mode == 1'b0) begin
                    rq.dsec  = 32'd0;
                    rq.dnsec = 30'($urandom_range(12));
                end else if (pick != 0) begin
                    rq.dsec  = 32'($urandom_range(2));
                    rq.dnsec = 30'($urandom_range(NSEC_MAX));
                end
            end else if (pick < 94) begin
                rq.op = OP_SCAN;
            end else begin
                rq.op = OP_UNUSED;
            end
            push_request(rq);
        end
    endtask

    task automatic run_phase(input logic mode, input logic [31:0] ticks,
                             input logic [29:0] step, input int count,
                             input int send_pct, input int recv_pct, input bit hold);
        write_register(CFG_COUNT_MODE, {31'($urandom), mode});
        write_register(CFG_TICKS_PER_NSEC, ticks);
        write_register(CFG_NSEC_PER_TICK, {2'($urandom_range(3)), step});
        i_cfg_we <= 1'b0;
        cfg_mode  = mode;
        cfg_ticks = ticks;
        cfg_step  = step;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        want_hold_off = hold;
        run_random(count);
        wait_drained();
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (want_hold_off && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_out_ready <= 1'b0;
                for (int held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        clock_report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_reports.size() == 0) begin
                note_mismatch("report with none awaited", 64'd0, {63'd0, o_fired});
            end else begin
                want = awaited_reports.pop_front();
                check_field("fired", want.fired, o_fired);
                check_field("woken_slot", want.slot, o_woken_slot);
                check_field("time_sec", want.sec, o_time_sec);
                check_field("time_nsec", want.nsec, o_time_nsec);
                check_field("last", want.last, o_last);
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_COUNT_MODE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_op         = OP_TICK;
        i_slot       = '0;
        i_delay_sec  = '0;
        i_delay_nsec = '0;
        clk_sec   = '0;
        clk_nsec  = '0;
        div_phase = '0;
        cfg_mode  = 1'b0;
        cfg_ticks = 32'd1;
        cfg_step  = 30'd1;
        foreach (slot_armed[i])
            slot_armed[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 87;
        foreach (directed_rows[r])
            push_request(directed_rows[r]);
        wait_drained();

        run_phase(1'b1, 32'd1, NSEC_MAX, 34, 36, 87, 1'b0);
        run_phase(1'b0, 32'd0, 30'd0, 34, 36, 87, 1'b0);
        run_phase(1'b1, 32'd0, 30'h3FFF_FFFF, 34, 36, 87, 1'b0);
        // let the phase build up, then shrink the divisor below it
        run_phase(1'b0, 32'hFFFF_FFFF, 30'd1, 20, 87, 36, 1'b0);
        run_phase(1'b0, 32'd3, 30'd1, 34, 87, 36, 1'b0);
        run_phase(1'b1, 32'd3, 30'd0, 30, 87, 36, 1'b0);
        run_phase(1'b1, 32'd2, 30'd300000007, 40, 0, 0, 1'b1);
        run_phase(1'b0, 32'd2, 30'd12345, 34, 0, 0, 1'b0);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
